// ===== design/idpa_pkg.sv =====
`timescale 1ns / 1ps

package idpa_pkg;

   // Number of entries in the freed-identifier FIFO
   localparam int SLOTS    = 512;
   localparam int ID_W     = 9;
   localparam int PAGE_W   = 10;
   localparam int PTR_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int FRESH_W  = PAGE_W;

   localparam logic [PAGE_W-1:0] ID_SPACE        = PAGE_W'(2 ** ID_W);
   localparam logic [PAGE_W-1:0] PAGE_SIZE_RESET = PAGE_W'(500);
   localparam logic [PTR_W-1:0]  PTR_LAST        = PTR_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL        = CNT_W'(SLOTS);

   typedef enum logic {
      FUNC_ALLOC   = 1'b0,
      FUNC_RELEASE = 1'b1
   } func_type;

   typedef struct packed {
      func_type         func;
      logic [ID_W-1:0]  slot_id;
   } item_type;

   typedef struct packed {
      logic [ID_W-1:0]  granted_id;
      logic             ok;
      logic             page_full;
   } result_type;

   // Identifiers are ID_W bits wide, so the counter never goes past ID_SPACE
   function automatic logic [PAGE_W-1:0] page_limit(input logic [PAGE_W-1:0] page_size);
      page_limit = (page_size > ID_SPACE) ? ID_SPACE : page_size;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      ptr_next = (ptr == PTR_LAST) ? '0 : ptr + PTR_W'(1);
   endfunction

endpackage

// ===== design/idpa_ram.sv =====
`timescale 1ns / 1ps

module idpa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 512
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/idpa_engine.sv =====
`timescale 1ns / 1ps

module idpa_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [idpa_pkg::PAGE_W-1:0]  page_size,
   input  logic                         fire,
   input  idpa_pkg::item_type           item,
   output idpa_pkg::result_type         result
);

   logic [idpa_pkg::FRESH_W-1:0] fresh_ff, fresh_in;
   logic [idpa_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [idpa_pkg::PTR_W-1:0]   tail_ff, tail_in;
   logic [idpa_pkg::CNT_W-1:0]   count_ff, count_in;
   logic                         bypass_ff, bypass_in;
   logic [idpa_pkg::ID_W-1:0]    bypass_data_ff;

   logic [idpa_pkg::PAGE_W-1:0]  limit;
   logic [idpa_pkg::ID_W-1:0]    ram_rd_data;
   logic [idpa_pkg::ID_W-1:0]    head_data;
   logic                         push;
   logic [idpa_pkg::ID_W-1:0]    granted;
   logic                         ok;
   logic [idpa_pkg::FRESH_W-1:0] id_plus_one;

   assign limit       = idpa_pkg::page_limit(page_size);
   assign id_plus_one = idpa_pkg::FRESH_W'(item.slot_id) + idpa_pkg::FRESH_W'(1);

   // A write landing on the address being read this edge forwards its data
   assign head_data = bypass_ff ? bypass_data_ff : ram_rd_data;

   always_comb begin
      fresh_in = fresh_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      push     = 1'b0;
      granted  = '0;
      ok       = 1'b0;
      unique case (item.func)
         idpa_pkg::FUNC_ALLOC: begin
            if (count_ff != '0) begin
               granted  = head_data;
               head_in  = idpa_pkg::ptr_next(head_ff);
               count_in = count_ff - idpa_pkg::CNT_W'(1);
               ok       = 1'b1;
            end else if (fresh_ff < limit) begin
               granted  = fresh_ff[idpa_pkg::ID_W-1:0];
               fresh_in = fresh_ff + idpa_pkg::FRESH_W'(1);
               ok       = 1'b1;
            end
         end
         idpa_pkg::FUNC_RELEASE: begin
            // shrink the counter when the top identifier comes back
            if (fresh_ff != '0 && fresh_ff == id_plus_one) begin
               fresh_in = fresh_ff - idpa_pkg::FRESH_W'(1);
               ok       = 1'b1;
            end else if (count_ff < idpa_pkg::CNT_FULL) begin
               push     = 1'b1;
               tail_in  = idpa_pkg::ptr_next(tail_ff);
               count_in = count_ff + idpa_pkg::CNT_W'(1);
               ok       = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!fire) begin
         fresh_in = fresh_ff;
         head_in  = head_ff;
         tail_in  = tail_ff;
         count_in = count_ff;
         push     = 1'b0;
      end
   end

   assign bypass_in = push && (tail_ff == head_in);

   assign result.granted_id = granted;
   assign result.ok         = ok;
   assign result.page_full  = (count_in == '0) && (fresh_in == limit);

   // Prefetch the head entry for whichever item is processed next
   idpa_ram #(
      .WIDTH (idpa_pkg::ID_W),
      .DEPTH (idpa_pkg::SLOTS)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (tail_ff),
      .wr_data (item.slot_id),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         bypass_ff <= 1'b0;
      end else begin
         fresh_ff  <= fresh_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         bypass_ff <= bypass_in;
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= item.slot_id;
   end

endmodule

// ===== design/id_page_allocator_with_shrink.sv =====
`timescale 1ns / 1ps

// Slot identifier allocator for one page. An allocate beat returns the oldest
// identifier from the freed FIFO, or else the next value of the bump counter
// while it is below min(page_size, 512); a release of the identifier just
// below the counter shrinks the counter, any other release is queued in the
// 512-entry freed FIFO (dropped with ok low when the FIFO is full). Every
// request gives exactly one response; the request is registered in s1 and its
// result in the response register, held while rsp_stall is high. One request
// per cycle is sustained while rsp_stall is low. The freed FIFO lives in a RAM
// with registered read whose head entry is prefetched from head_in, so a pop
// never adds latency. The user must write page_size (500 at reset) through
// the csr port only while no request is in flight; the block does not enforce it.
module id_page_allocator_with_shrink (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [idpa_pkg::PAGE_W-1:0]  csr_page_size,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_func,
   input  logic [idpa_pkg::ID_W-1:0]    req_slot_id,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [idpa_pkg::ID_W-1:0]    rsp_granted_id,
   output logic                         rsp_ok,
   output logic                         rsp_page_full
);

   logic [idpa_pkg::PAGE_W-1:0] page_size_ff;
   logic                        s1_valid_ff, s1_valid_in;
   idpa_pkg::item_type          s1_item_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   idpa_pkg::result_type        rsp_data_ff;
   idpa_pkg::result_type        result;
   logic                        advance;
   logic                        fire;
   logic                        req_accept;

   assign csr_ready = 1'b1;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign fire       = s1_valid_ff && advance;
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);

   idpa_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .page_size (page_size_ff),
      .fire      (fire),
      .item      (s1_item_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_size_ff <= idpa_pkg::PAGE_SIZE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            page_size_ff <= csr_page_size;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payloads while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.func    <= idpa_pkg::func_type'(req_func);
         s1_item_ff.slot_id <= req_slot_id;
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_granted_id = rsp_data_ff.granted_id;
   assign rsp_ok         = rsp_data_ff.ok;
   assign rsp_page_full  = rsp_data_ff.page_full;

endmodule

// ===== sim/idpa_grant_checker.sv =====
`timescale 1ns / 1ps

module idpa_grant_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [idpa_pkg::PAGE_W-1:0]   csr_page_size,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_func,
   input  logic [idpa_pkg::ID_W-1:0]     req_slot_id,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [idpa_pkg::ID_W-1:0]     rsp_granted_id,
   input  logic                          rsp_ok,
   input  logic                          rsp_page_full,
   output int                            mismatches,
   output int                            pending,
   output logic [idpa_pkg::FRESH_W-1:0]  fresh_count
);

   // Replies in flight; the block holds no more than two
   localparam int DUE_DEPTH = 16;

   logic [idpa_pkg::PAGE_W-1:0]  page_size_q;
   logic [idpa_pkg::FRESH_W-1:0] fresh_q;
   logic [idpa_pkg::ID_W-1:0]    freed_q [idpa_pkg::SLOTS];
   logic [idpa_pkg::PTR_W-1:0]   head_q;
   logic [idpa_pkg::PTR_W-1:0]   tail_q;
   logic [idpa_pkg::CNT_W-1:0]   held_q;
   idpa_pkg::result_type         due_ring [DUE_DEPTH];
   int                           due_rd = 0;
   int                           due_wr = 0;
   int                           fails = 0;

   assign mismatches = fails;

   // Apply one request beat to the shadow page and return the reply it earns.
   function automatic idpa_pkg::result_type serve_request(input idpa_pkg::item_type beat);
      idpa_pkg::result_type        r;
      logic [idpa_pkg::PAGE_W-1:0] lim;
      lim = (page_size_q > idpa_pkg::ID_SPACE) ? idpa_pkg::ID_SPACE : page_size_q;
      r = '0;
      if (beat.func == idpa_pkg::FUNC_ALLOC) begin
         if (held_q != '0) begin
            r.granted_id = freed_q[head_q];
            head_q = head_q + idpa_pkg::PTR_W'(1);
            held_q = held_q - idpa_pkg::CNT_W'(1);
            r.ok = 1'b1;
         end else if (fresh_q < lim) begin
            r.granted_id = fresh_q[idpa_pkg::ID_W-1:0];
            fresh_q = fresh_q + idpa_pkg::FRESH_W'(1);
            r.ok = 1'b1;
         end
      end else begin
         if (fresh_q != '0 &&
             fresh_q == idpa_pkg::FRESH_W'(beat.slot_id) + idpa_pkg::FRESH_W'(1)) begin
            fresh_q = fresh_q - idpa_pkg::FRESH_W'(1);
            r.ok = 1'b1;
         end else if (held_q < idpa_pkg::CNT_FULL) begin
            freed_q[tail_q] = beat.slot_id;
            tail_q = tail_q + idpa_pkg::PTR_W'(1);
            held_q = held_q + idpa_pkg::CNT_W'(1);
            r.ok = 1'b1;
         end
      end
      r.page_full = (held_q == '0) && (fresh_q == lim);
      return r;
   endfunction

   always @(posedge clock) begin
      idpa_pkg::result_type want;
      idpa_pkg::item_type   beat;
      if (reset) begin
         page_size_q = idpa_pkg::PAGE_SIZE_RESET;
         fresh_q = '0;
         head_q = '0;
         tail_q = '0;
         held_q = '0;
         due_rd = 0;
         due_wr = 0;
      end else begin
         if (csr_valid && csr_ready)
            page_size_q = csr_page_size;
         // Retire the oldest reply before queuing this edge's request.
         if (rsp_valid && !rsp_stall) begin
            if (due_wr == due_rd) begin
               fails++;
               $error("unrequested reply: granted_id %0d ok %0d page_full %0d",
                      rsp_granted_id, rsp_ok, rsp_page_full);
            end else begin
               want = due_ring[due_rd % DUE_DEPTH];
               due_rd++;
               if (rsp_granted_id !== want.granted_id) begin
                  fails++;
                  $error("granted_id: expected %0d, actual %0d",
                         want.granted_id, rsp_granted_id);
               end
               if (rsp_ok !== want.ok) begin
                  fails++;
                  $error("ok: expected %0d, actual %0d", want.ok, rsp_ok);
               end
               if (rsp_page_full !== want.page_full) begin
                  fails++;
                  $error("page_full: expected %0d, actual %0d",
                         want.page_full, rsp_page_full);
               end
            end
         end
         if (req_valid && !req_stall) begin
            beat.func = idpa_pkg::func_type'(req_func);
            beat.slot_id = req_slot_id;
            if (due_wr - due_rd >= DUE_DEPTH) begin
               fails++;
               $error("too many requests without a reply");
            end else begin
               due_ring[due_wr % DUE_DEPTH] = serve_request(beat);
               due_wr++;
            end
         end
      end
      pending <= due_wr - due_rd;
      fresh_count <= fresh_q;
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

   // Longest correct quiet spell is the HOLD_CYCLES reply hold-off plus a few gaps.
   localparam int QUIET_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [idpa_pkg::PAGE_W-1:0]   csr_page_size;
   logic                          req_valid;
   logic                          req_stall;
   logic                          req_func;
   logic [idpa_pkg::ID_W-1:0]     req_slot_id;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [idpa_pkg::ID_W-1:0]     rsp_granted_id;
   logic                          rsp_ok;
   logic                          rsp_page_full;
   int                            mismatches;
   int                            pending;
   logic [idpa_pkg::FRESH_W-1:0]  fresh_count;
   logic                          flood_on = 1'b0;
   logic                          calm = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   id_page_allocator_with_shrink i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_page_size  (csr_page_size),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_slot_id    (req_slot_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted_id (rsp_granted_id),
      .rsp_ok         (rsp_ok),
      .rsp_page_full  (rsp_page_full)
   );

   idpa_grant_checker i_check (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_page_size  (csr_page_size),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_slot_id    (req_slot_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_granted_id (rsp_granted_id),
      .rsp_ok         (rsp_ok),
      .rsp_page_full  (rsp_page_full),
      .mismatches     (mismatches),
      .pending        (pending),
      .fresh_count    (fresh_count)
   );

   // Reply side: random stalls, one long hold-off once the flood phase starts.
   initial begin
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (flood_on && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= !calm && ($urandom_range(99) < 11);
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_item(input idpa_pkg::func_type f,
                            input logic [idpa_pkg::ID_W-1:0] id);
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(2, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_slot_id <= id;
      do @(posedge clock); while (!req_valid || req_stall);
   endtask

   // Drop valid and hold until every reply is back, plus a little pipeline slack.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_page(input logic [idpa_pkg::PAGE_W-1:0] size);
      settle();
      csr_valid <= 1'b1;
      csr_page_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Releases aim at the counter top shrink_pct of the time to walk it back down.
   task automatic run_mix(input int count, input int release_pct, input int shrink_pct,
                          input int id_top);
      idpa_pkg::func_type          f;
      logic [idpa_pkg::ID_W-1:0]   id;
      repeat (count) begin
         f = ($urandom_range(99) < release_pct) ? idpa_pkg::FUNC_RELEASE
                                                : idpa_pkg::FUNC_ALLOC;
         if (f == idpa_pkg::FUNC_RELEASE && $urandom_range(99) < shrink_pct)
            id = idpa_pkg::ID_W'(fresh_count - 1);
         else
            id = idpa_pkg::ID_W'($urandom_range(id_top));
         send_item(f, id);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_page_size <= '0;
      req_valid <= 1'b0;
      req_func <= idpa_pkg::FUNC_ALLOC;
      req_slot_id <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset page size: bump, shrink, queue and reuse freed ids.
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd511);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd2);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd511);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd300);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);

      // Zero page below a live counter, then walk the counter down to empty.
      write_page(10'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd2);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd1);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd5);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);

      write_page(10'd1);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_ALLOC, 9'd0);
      send_item(idpa_pkg::FUNC_RELEASE, 9'd0);

      write_page(10'd16);
      run_mix(150, 40, 50, 31);
      write_page(10'd4);
      run_mix(80, 60, 60, 15);
      write_page(10'd1);
      run_mix(60, 50, 50, 3);
      write_page(10'd0);
      run_mix(40, 50, 50, 3);

      // Oversized page, nearly all releases: fill the freed queue past full.
      write_page(10'd1023);
      flood_on <= 1'b1;
      run_mix(560, 97, 2, 511);

      write_page(10'd512);
      calm <= 1'b1;
      run_mix(150, 20, 30, 511);

      settle();
      if (mismatches == 0 && pending == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
design/idpa_pkg.sv
design/idpa_ram.sv
design/idpa_engine.sv
design/id_page_allocator_with_shrink.sv
sim/idpa_grant_checker.sv
sim/tb.sv
